>>> src/me_pkg.sv
package me_pkg;

    // Operand width of the input fields; the serial multiplier steps through this many bits.
    localparam int OPER_W = 32;
    localparam int STEP_W = $clog2(OPER_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_REDUCE,
        ST_BIT,
        ST_MUL,
        ST_SQUARE,
        ST_DONE
    } me_state_t;

    typedef struct packed {
        logic load_item;
        logic clear_acc;
        logic start_reduce;
        logic start_mul;
        logic start_square;
        logic write_pw;
        logic write_acc;
        logic shift_exp;
        logic load_result;
    } me_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic mul_done;
    } me_status_t;

endpackage

>>> src/me_mulred.sv
module me_mulred
    import me_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WIDTH-1:0]     mcand,
    input  logic [OPER_W-1:0]    mplier,
    input  logic [WIDTH-1:0]     modulus,
    output logic                 done,
    output logic [WIDTH-1:0]     prod
);

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [STEP_W-1:0]   cnt_reg;
    logic [STEP_W-1:0]   cnt_next;
    logic [WIDTH-1:0]    r_reg;
    logic [WIDTH-1:0]    r_next;
    logic [WIDTH-1:0]    a_reg;
    logic [WIDTH-1:0]    a_next;
    logic [OPER_W-1:0]   m_reg;
    logic [OPER_W-1:0]   m_next;

    logic [WIDTH:0]      dbl;
    logic [WIDTH-1:0]    dbl_red;
    logic [WIDTH:0]      sum;
    logic [WIDTH-1:0]    sum_red;

    // One step of MSB-first interleaved multiply and reduce: r = (2r + bit*a) mod n.
    // Both partial values stay below 2n, so one conditional subtract each suffices.
    always_comb
    begin
        dbl = {r_reg, 1'b0};
        if (dbl >= {1'b0, modulus})
        begin
            dbl = dbl - {1'b0, modulus};
        end
        dbl_red = dbl[WIDTH-1:0];
        sum = {1'b0, dbl_red} + (m_reg[OPER_W-1] ? {1'b0, a_reg} : '0);
        if (sum >= {1'b0, modulus})
        begin
            sum = sum - {1'b0, modulus};
        end
        sum_red = sum[WIDTH-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        m_next    = m_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(OPER_W - 1);
            r_next    = '0;
            a_next    = mcand;
            m_next    = mplier;
        end
        else if (busy_reg)
        begin
            r_next   = sum_red;
            m_next   = {m_reg[OPER_W-2:0], 1'b0};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        r_reg   <= r_next;
        a_reg   <= a_next;
        m_reg   <= m_next;
    end

    assign done = done_reg;
    assign prod = r_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("multiplier done without a running product");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == '0) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after its last step");

endmodule

>>> src/me_datapath.sv
module me_datapath
    import me_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  me_cmd_t              cmd,
    output me_status_t           status,
    input  logic [WIDTH-1:0]     modulus,
    input  logic [OPER_W-1:0]    base_value,
    input  logic [OPER_W-1:0]    exponent,
    output logic [OPER_W-1:0]    result
);

    logic [WIDTH-1:0]    acc_reg;
    logic [WIDTH-1:0]    acc_next;
    logic [WIDTH-1:0]    pw_reg;
    logic [WIDTH-1:0]    pw_next;
    logic [OPER_W-1:0]   exp_reg;
    logic [OPER_W-1:0]   exp_next;
    logic [OPER_W-1:0]   base_reg;
    logic [OPER_W-1:0]   base_next;
    logic [OPER_W-1:0]   result_reg;
    logic [OPER_W-1:0]   result_next;

    logic                mul_start;
    logic [WIDTH-1:0]    mul_mcand;
    logic [OPER_W-1:0]   mul_mplier;
    logic                mul_done;
    logic [WIDTH-1:0]    mul_prod;
    logic                mod_one;

    assign mod_one = (modulus == WIDTH'(1));

    // Reducing the base is a product with one (or zero when the modulus is one, so the
    // multiplicand stays below the modulus) and the full 32-bit base as multiplier.
    always_comb
    begin
        mul_start  = cmd.start_reduce | cmd.start_mul | cmd.start_square;
        mul_mcand  = pw_reg;
        mul_mplier = OPER_W'(pw_reg);
        if (cmd.start_reduce)
        begin
            mul_mcand  = mod_one ? '0 : WIDTH'(1);
            mul_mplier = base_reg;
        end
        else if (cmd.start_mul)
        begin
            mul_mplier = OPER_W'(acc_reg);
        end
    end

    me_mulred #(
        .WIDTH (WIDTH)
    ) u_mulred (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .modulus (modulus),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    always_comb
    begin
        acc_next    = acc_reg;
        pw_next     = pw_reg;
        exp_next    = exp_reg;
        base_next   = base_reg;
        result_next = result_reg;
        if (cmd.load_item)
        begin
            acc_next  = WIDTH'(1);
            exp_next  = exponent;
            base_next = base_value;
        end
        if (cmd.clear_acc)
        begin
            acc_next = '0;
        end
        if (cmd.write_acc)
        begin
            acc_next = mul_prod;
        end
        if (cmd.write_pw)
        begin
            pw_next = mul_prod;
        end
        if (cmd.shift_exp)
        begin
            exp_next = {1'b0, exp_reg[OPER_W-1:1]};
        end
        if (cmd.load_result)
        begin
            result_next = OPER_W'(acc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        pw_reg     <= pw_next;
        exp_reg    <= exp_next;
        base_reg   <= base_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        status.mod_zero = (modulus == '0);
        status.exp_zero = (exp_reg == '0);
        status.exp_lsb  = exp_reg[0];
        status.mul_done = mul_done;
    end

    assign result = result_reg;

endmodule

>>> src/me_ctrl.sv
module me_ctrl
    import me_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    output logic        result_valid,
    input  logic        result_ready,
    input  me_status_t  status,
    output me_cmd_t     cmd
);

    me_state_t  state_reg;
    me_state_t  state_next;
    logic       result_valid_reg;
    logic       result_valid_next;
    logic       out_free;

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = status.mod_zero ? ST_DONE : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                if (status.exp_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (status.exp_lsb)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_MUL:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_BIT;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.load_item = item_valid;
            end
            ST_PREP:
            begin
                cmd.clear_acc    = status.mod_zero;
                cmd.start_reduce = !status.mod_zero;
            end
            ST_REDUCE:
            begin
                cmd.write_pw = status.mul_done;
            end
            ST_BIT:
            begin
                cmd.start_mul    = !status.exp_zero && status.exp_lsb;
                cmd.start_square = !status.exp_zero && !status.exp_lsb;
            end
            ST_MUL:
            begin
                cmd.write_acc    = status.mul_done;
                cmd.start_square = status.mul_done;
            end
            ST_SQUARE:
            begin
                cmd.write_pw  = status.mul_done;
                cmd.shift_exp = status.mul_done;
            end
            ST_DONE:
            begin
                cmd.load_result = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!result_valid_reg || result_ready))
        else $error("result overwritten before it was taken");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> result_valid_reg)
        else $error("loaded result not presented");

    a_item_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == ST_PREP))
        else $error("accepted beat did not start a computation");

endmodule

>>> src/modular_exponentiation.sv
// Modular exponentiation, right-to-left binary square-and-multiply, one result beat per item.
// Each modular product runs on a bit-serial multiply-reduce unit in 32 steps.
// An item needs one product to reduce the base, one squaring per exponent bit up to the
// highest set bit, and one multiply per set bit.
// One item is in work at a time; a new item is accepted while the previous result waits.
// Reset (rst_n low, asynchronous) empties the block and sets the modulus to 1.
module modular_exponentiation
    import me_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration: the modulus register.
    input  logic                 cfg_wr_en,
    input  logic [OPER_W-1:0]    cfg_wr_data,

    // Input items.
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [OPER_W-1:0]    base_value,
    input  logic [OPER_W-1:0]    exponent,

    // Result items.
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [OPER_W-1:0]    result
);

    // The modulus keeps only its low WIDTH bits, so every partial sum of the multiply-reduce unit fits in WIDTH+1 bits.
    logic [WIDTH-1:0]  modulus_reg;
    logic [WIDTH-1:0]  modulus_next;

    me_cmd_t     cmd;
    me_status_t  status;

    always_comb
    begin
        modulus_next = modulus_reg;
        if (cfg_wr_en)
        begin
            modulus_next = cfg_wr_data[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= WIDTH'(1);
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    // The controller sequences base reduction, then per exponent bit an optional multiply
    // into the accumulator and a squaring of the running power. A zero modulus skips all
    // arithmetic and returns zero; a zero exponent returns one.
    me_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds the accumulator, power, exponent shifter, result register and
    // the shared multiply-reduce unit.
    me_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .modulus    (modulus_reg),
        .base_value (base_value),
        .exponent   (exponent),
        .result     (result)
    );

endmodule

>>> tb/tb_modular_exponentiation.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation;
    import me_pkg::*;

    // Clock and run limits. The drain window at the end covers one full item, even the
    // slowest. The hard limit is several times the slowest possible run of about 300
    // items with stalls on both sides.
    localparam int      CLK_PERIOD   = 10;
    localparam int      RESET_CYCLES = 11;
    localparam int      DRAIN_CYCLES = 2200;
    localparam longint  RUN_LIMIT_NS = 64'd50_000_000;
    localparam int      MAX_REPORTS  = 10;
    localparam int      RANDOM_PHASES = 9;
    localparam int      PHASE_ITEMS   = 30;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [OPER_W-1:0]    cfg_wr_data;
    logic                 item_valid;
    logic                 item_ready;
    logic [OPER_W-1:0]    base_value;
    logic [OPER_W-1:0]    exponent;
    logic                 result_valid;
    logic                 result_ready;
    logic [OPER_W-1:0]    result;

    // Chance, in percent, that a side idles in a given cycle.
    int sender_idle_pct;
    int receiver_idle_pct;

    // The scoreboard keeps its own copy of the modulus register and a FIFO of the
    // results that accepted input beats are due to produce, oldest first.
    class modexp_scoreboard;
        logic [OPER_W-1:0] modulus;
        logic [OPER_W-1:0] expected_results[$];
        int unsigned       mismatch_count;

        function new();
            modulus = 1;
            mismatch_count = 0;
        endfunction

        // Right-to-left square-and-multiply. Operands stay below 2^OPER_W, so the
        // double-width products never overflow. A zero modulus yields zero, and a
        // zero exponent yields one even when the modulus is one.
        function logic [OPER_W-1:0] power_mod(input logic [OPER_W-1:0] b,
                                              input logic [OPER_W-1:0] e,
                                              input logic [OPER_W-1:0] n);
            logic [2*OPER_W-1:0] acc;
            logic [2*OPER_W-1:0] pw;
            logic [OPER_W-1:0]   rest;
            if (n == '0)
                return '0;
            acc  = 1;
            pw   = b % n;
            rest = e;
            while (rest != '0)
            begin
                if (rest[0])
                    acc = (acc * pw) % n;
                pw   = (pw * pw) % n;
                rest = rest >> 1;
            end
            return acc[OPER_W-1:0];
        endfunction

        function void note_item(input logic [OPER_W-1:0] b, input logic [OPER_W-1:0] e);
            expected_results.push_back(power_mod(b, e, modulus));
        endfunction

        function void check_result(input logic [OPER_W-1:0] actual);
            logic [OPER_W-1:0] wanted;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat 0x%08h arrived with nothing expected",
                             $time, actual);
                return;
            end
            wanted = expected_results.pop_front();
            if (actual !== wanted)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result mismatch, expected 0x%08h, got 0x%08h",
                             $time, wanted, actual);
            end
        endfunction
    endclass

    modexp_scoreboard sb;

    modular_exponentiation #(
        .WIDTH(32)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .base_value   (base_value),
        .exponent     (exponent),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The receiver decides its ready at every falling edge. A ready during reset is
    // harmless because no result can be valid then.
    initial result_ready = 1'b0;
    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= receiver_idle_pct);

    // Both handshakes are sampled at the rising edge, where every testbench-driven
    // input has been stable since the falling edge. An input beat is noted before a result
    // beat of the same edge is checked; the result always belongs to an older item.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            sb.note_item(base_value, exponent);
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // Presents one input beat and returns at the rising edge that accepts it. The
    // sender may idle first; valid is only lowered in cycles where it really idles,
    // so a back-to-back beat never sees valid dropped and raised in one step.
    task automatic send_item(input logic [OPER_W-1:0] b, input logic [OPER_W-1:0] e);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        base_value <= b;
        exponent   <= e;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Stops sending and waits until every expected result has been taken. Since
    // every item gives exactly one result, the block is idle after that.
    task automatic wait_until_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
    endtask

    // The modulus is only changed while the block is idle, and the scoreboard copy
    // follows at the same time.
    task automatic write_modulus(input logic [OPER_W-1:0] value);
        wait_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.modulus  = value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Bases: mostly full-range values, plus multiples of the modulus (reduce to
    // zero unless they wrap past 32 bits), the value just below the modulus, and small values.
    function automatic logic [OPER_W-1:0] pick_base();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom;
        else if (sel < 80)
            return sb.modulus * $urandom_range(0, 7);
        else if (sel < 90)
            return sb.modulus - 1;
        else
            return $urandom_range(0, 15);
    endfunction

    // Exponents: half full-range (the slow, deep case), the rest short exponents,
    // zero and one, single set bits and random lengths, which keep the run short
    // and vary how many bits the block scans.
    function automatic logic [OPER_W-1:0] pick_exponent();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return $urandom;
        else if (sel < 70)
            return $urandom_range(0, 255);
        else if (sel < 80)
            return $urandom_range(0, 1);
        else if (sel < 90)
            return 32'd1 << $urandom_range(0, OPER_W - 1);
        else
            return $urandom >> $urandom_range(0, OPER_W - 1);
    endfunction

    function automatic logic [OPER_W-1:0] pick_modulus(input int phase);
        logic [OPER_W-1:0] value;
        case (phase)
            0: value = 32'hFFFF_FFFB;
            1: value = $urandom | 32'h8000_0000;
            2: value = $urandom_range(3, 255);
            3: value = 32'd1;
            4: value = $urandom | 32'd1;
            5: value = ($urandom & 32'hFFFF_FFFE) | 32'd2;
            6: value = $urandom_range(2, 65535);
            7: value = 32'h8000_0000;
            default: value = $urandom;
        endcase
        if (value == '0)
            value = 32'd7;
        return value;
    endfunction

    // One random phase under a fixed modulus. When asked, the sender holds off
    // halfway until every result so far has come back.
    task automatic run_random_phase(input int count, input bit hold_midway);
        for (int i = 0; i < count; i++)
        begin
            if (hold_midway && i == count / 2)
                wait_until_drained();
            send_item(pick_base(), pick_exponent());
        end
    endtask

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        item_valid  = 1'b0;
        base_value  = '0;
        exponent    = '0;
        sender_idle_pct   = 32;
        receiver_idle_pct = 70;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats. Under the reset modulus of one, every result is zero
        // except for a zero exponent, which gives one.
        send_item(32'd0, 32'd0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'd7, 32'd0);
        send_item(32'd1, 32'd5);

        // Largest modulus: operand extremes, a base equal to the modulus, the
        // value just below it, and exponents with only the top bit or all bits set.
        write_modulus(32'hFFFF_FFFF);
        send_item(32'd0, 32'd0);
        send_item(32'd0, 32'd5);
        send_item(32'd1, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd3);
        send_item(32'hFFFF_FFFE, 32'd2);
        send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_item(32'd2, 32'd32);
        send_item(32'h1234_5678, 32'd1);
        send_item(32'hDEAD_BEEF, 32'h8000_0000);
        send_item(32'd3, 32'hFFFF_FFFF);

        // A zero modulus can be written even though it is not meaningful; the block
        // then does no arithmetic and returns zero, also for a zero exponent.
        write_modulus(32'd0);
        send_item(32'd0, 32'd0);
        send_item(32'd5, 32'd7);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Smallest useful modulus.
        write_modulus(32'd2);
        send_item(32'd3, 32'hFFFF_FFFF);
        send_item(32'd4, 32'd1);
        send_item(32'hFFFF_FFFF, 32'd0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random phases, each under its own modulus. The first third has a busy
        // sender and a slow receiver, the next third the reverse, the last third
        // runs with both sides always ready.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_modulus(pick_modulus(phase));
            if (phase < 3)
            begin
                sender_idle_pct   = 32;
                receiver_idle_pct = 70;
            end
            else if (phase < 6)
            begin
                sender_idle_pct   = 70;
                receiver_idle_pct = 32;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            run_random_phase(PHASE_ITEMS, phase == 4);
        end

        // Drain: take every result at once, then give the block one more item time
        // to show any stray result beat.
        @(negedge clk);
        item_valid <= 1'b0;
        receiver_idle_pct = 0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
src/me_pkg.sv
src/me_mulred.sv
src/me_datapath.sv
src/me_ctrl.sv
src/modular_exponentiation.sv
tb/tb_modular_exponentiation.sv
